/* rtl/circle_overlap_push_vector_assert.svh */
// Assertion macros for the circle overlap push vector checker.
// Used by the checker file only; needs clk and rst_n in scope.
`ifndef CIRCLE_OVERLAP_PUSH_VECTOR_ASSERT_SVH
`define CIRCLE_OVERLAP_PUSH_VECTOR_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define COPV_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define COPV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/copv_pkg.sv */
// Shared sizing helpers for the circle overlap push vector.
// No dependencies.
package copv_pkg;

    // Bits of the root and quotient: one cell per bit.
    function automatic int root_bits(input int coord_bits);
        return coord_bits + 2;
    endfunction

    // Bits of the running remainder in the root and divide cells.
    function automatic int rem_bits(input int coord_bits);
        return 2 * coord_bits + 4;
    endfunction

endpackage

/* rtl/copv_if.sv */
// Valid/ready channel interfaces for the circle overlap push vector.
// No dependencies.
interface copv_in_if #(parameter int COORD_BITS = 16) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] first_x;
    logic signed [COORD_BITS-1:0] first_y;
    logic        [COORD_BITS-1:0] first_radius;
    logic signed [COORD_BITS-1:0] second_x;
    logic signed [COORD_BITS-1:0] second_y;
    logic        [COORD_BITS-1:0] second_radius;

    modport source (output valid, first_x, first_y, first_radius,
                    second_x, second_y, second_radius, input ready);
    modport sink   (input valid, first_x, first_y, first_radius,
                    second_x, second_y, second_radius, output ready);
endinterface

interface copv_out_if #(parameter int COORD_BITS = 16) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS+1:0] push_x;
    logic signed [COORD_BITS+1:0] push_y;
    logic                         in_contact;

    modport source (output valid, push_x, push_y, in_contact, input ready);
    modport sink   (input valid, push_x, push_y, in_contact, output ready);
endinterface

/* rtl/circle_overlap_push_vector.sv */
// Circle overlap push vector: top level pipeline.
// Depends on copv_pkg, copv_if, copv_sqrt_cell and copv_div_cell.
//
//   channel | dir | payload
//   in      | in  | first_x, first_y, first_radius, second_x, second_y, second_radius
//   out     | out | push_x, push_y, in_contact
//
// One transaction per cycle unless the output stalls. The pipeline holds a row of
// COORD_BITS+2 root cells, COORD_BITS+2 divide cells and six register stages around them.
// rst_n clears only the valid bits of the stages.
// A stalled output freezes the whole pipeline; bubbles are not squeezed out.
module circle_overlap_push_vector #(
    parameter int COORD_BITS = 16
) (
    input logic     clk,
    input logic     rst_n,
    copv_in_if.sink  in,
    copv_out_if.source out
);
    import copv_pkg::*;

    localparam int CW = COORD_BITS + 1;
    localparam int RW = root_bits(COORD_BITS);
    localparam int W2 = rem_bits(COORD_BITS);
    localparam int SQ_SW = 3 + 3 * CW;
    localparam int DV_SW = 3;
    localparam int N  = 2 * RW + 6;

    logic          en;
    logic [N-1:0]  vld_reg;

    // stage 0: differences, magnitudes, radius sum
    logic signed [CW-1:0] dx_n;
    logic signed [CW-1:0] dy_n;
    logic [CW-1:0] adx0_reg, ady0_reg, sum0_reg;
    logic          sx0_reg, sy0_reg;

    // stage 1: squares
    logic [2*CW-1:0] sqx1_reg, sqy1_reg, sqs1_reg;
    logic [CW-1:0]   adx1_reg, ady1_reg, sum1_reg;
    logic            sx1_reg, sy1_reg;

    // stage 2: squared distance and contact
    logic [W2-1:0]   d2_n;
    logic [W2-1:0]   d2_reg;
    logic            ct2_reg;
    logic [CW-1:0]   adx2_reg, ady2_reg, sum2_reg;
    logic            sx2_reg, sy2_reg;

    logic [W2-1:0]    srem [RW+1];
    logic [RW-1:0]    sroot [RW+1];
    logic [SQ_SW-1:0] sside [RW+1];

    // stage A: overlap
    logic            a_ct, a_sx, a_sy;
    logic [CW-1:0]   a_adx, a_ady, a_sum;
    logic [CW-1:0]   ovl_reg, adxa_reg, adya_reg;
    logic [RW-1:0]   dena_reg;
    logic            zeroa_reg, cta_reg, sxa_reg, sya_reg;

    // stage B: numerators
    logic [2*CW-1:0] numx_reg, numy_reg;
    logic [RW-1:0]   denb_reg;
    logic            zerob_reg, ctb_reg, sxb_reg, syb_reg;

    logic [W2-1:0]    drx [RW+1];
    logic [W2-1:0]    dry [RW+1];
    logic [RW-1:0]    dqx [RW+1];
    logic [RW-1:0]    dqy [RW+1];
    logic [RW-1:0]    dden [RW+1];
    logic [DV_SW-1:0] dside [RW+1];

    logic          ct_reg;
    logic [RW-1:0] px_reg, py_reg;
    logic          o_zero, o_sx, o_sy;

    assign en       = !vld_reg[N-1] || out.ready;
    assign in.ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[N-2:0], in.valid};
        end
    end

    assign dx_n = {in.first_x[COORD_BITS-1], in.first_x}
                - {in.second_x[COORD_BITS-1], in.second_x};
    assign dy_n = {in.first_y[COORD_BITS-1], in.first_y}
                - {in.second_y[COORD_BITS-1], in.second_y};
    assign d2_n = W2'(sqx1_reg) + W2'(sqy1_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sx0_reg  <= dx_n[CW-1];
            sy0_reg  <= dy_n[CW-1];
            adx0_reg <= dx_n[CW-1] ? CW'(-dx_n) : CW'(dx_n);
            ady0_reg <= dy_n[CW-1] ? CW'(-dy_n) : CW'(dy_n);
            sum0_reg <= {1'b0, in.first_radius} + {1'b0, in.second_radius};

            sqx1_reg <= adx0_reg * adx0_reg;
            sqy1_reg <= ady0_reg * ady0_reg;
            sqs1_reg <= sum0_reg * sum0_reg;
            adx1_reg <= adx0_reg;
            ady1_reg <= ady0_reg;
            sum1_reg <= sum0_reg;
            sx1_reg  <= sx0_reg;
            sy1_reg  <= sy0_reg;

            d2_reg   <= d2_n;
            ct2_reg  <= (d2_n <= W2'(sqs1_reg));
            adx2_reg <= adx1_reg;
            ady2_reg <= ady1_reg;
            sum2_reg <= sum1_reg;
            sx2_reg  <= sx1_reg;
            sy2_reg  <= sy1_reg;
        end
    end

    assign srem[0]  = d2_reg;
    assign sroot[0] = '0;
    assign sside[0] = {ct2_reg, sx2_reg, sy2_reg, adx2_reg, ady2_reg, sum2_reg};

    for (genvar k = 0; k < RW; k++)
    begin : g_sqrt
        copv_sqrt_cell #(
            .COORD_BITS (COORD_BITS),
            .BIT        (RW - 1 - k),
            .SW         (SQ_SW)
        ) u_cell (
            .clk      (clk),
            .en       (en),
            .rem_in   (srem[k]),
            .root_in  (sroot[k]),
            .side_in  (sside[k]),
            .rem_out  (srem[k+1]),
            .root_out (sroot[k+1]),
            .side_out (sside[k+1])
        );
    end

    assign {a_ct, a_sx, a_sy, a_adx, a_ady, a_sum} = sside[RW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // root never exceeds the radius sum inside contact
            ovl_reg   <= a_sum - CW'(sroot[RW]);
            dena_reg  <= sroot[RW];
            zeroa_reg <= !a_ct || (sroot[RW] == '0);
            cta_reg   <= a_ct;
            sxa_reg   <= a_sx;
            sya_reg   <= a_sy;
            adxa_reg  <= a_adx;
            adya_reg  <= a_ady;

            numx_reg  <= adxa_reg * ovl_reg;
            numy_reg  <= adya_reg * ovl_reg;
            denb_reg  <= dena_reg;
            zerob_reg <= zeroa_reg;
            ctb_reg   <= cta_reg;
            sxb_reg   <= sxa_reg;
            syb_reg   <= sya_reg;
        end
    end

    assign drx[0]   = W2'(numx_reg);
    assign dry[0]   = W2'(numy_reg);
    assign dqx[0]   = '0;
    assign dqy[0]   = '0;
    assign dden[0]  = denb_reg;
    assign dside[0] = {zerob_reg, sxb_reg, syb_reg};

    // contact flag rides alongside the divider row
    logic [RW-1:0] ctd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctd_reg <= {ctd_reg[RW-2:0], ctb_reg};
        end
    end

    for (genvar k = 0; k < RW; k++)
    begin : g_div
        copv_div_cell #(
            .COORD_BITS (COORD_BITS),
            .BIT        (RW - 1 - k),
            .SW         (DV_SW)
        ) u_cell (
            .clk       (clk),
            .en        (en),
            .rem_x_in  (drx[k]),
            .rem_y_in  (dry[k]),
            .q_x_in    (dqx[k]),
            .q_y_in    (dqy[k]),
            .den_in    (dden[k]),
            .side_in   (dside[k]),
            .rem_x_out (drx[k+1]),
            .rem_y_out (dry[k+1]),
            .q_x_out   (dqx[k+1]),
            .q_y_out   (dqy[k+1]),
            .den_out   (dden[k+1]),
            .side_out  (dside[k+1])
        );
    end

    assign {o_zero, o_sx, o_sy} = dside[RW];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // drop the quotient when apart or when the centres coincide
            px_reg <= o_zero ? '0 : (o_sx ? RW'(-dqx[RW]) : dqx[RW]);
            py_reg <= o_zero ? '0 : (o_sy ? RW'(-dqy[RW]) : dqy[RW]);
            ct_reg <= ctd_reg[RW-1];
        end
    end

    assign out.valid      = vld_reg[N-1];
    assign out.push_x     = px_reg;
    assign out.push_y     = py_reg;
    assign out.in_contact = ct_reg;
endmodule

/* rtl/copv_sqrt_cell.sv */
// One bit of the pipelined integer square root: trial subtract and hold.
// Depends on copv_pkg.
module copv_sqrt_cell #(
    parameter int COORD_BITS = 16,
    parameter int BIT        = 0,
    parameter int SW         = 1
) (
    input  logic                                       clk,
    input  logic                                       en,
    input  logic [copv_pkg::rem_bits(COORD_BITS)-1:0]  rem_in,
    input  logic [copv_pkg::root_bits(COORD_BITS)-1:0] root_in,
    input  logic [SW-1:0]                              side_in,
    output logic [copv_pkg::rem_bits(COORD_BITS)-1:0]  rem_out,
    output logic [copv_pkg::root_bits(COORD_BITS)-1:0] root_out,
    output logic [SW-1:0]                              side_out
);
    import copv_pkg::*;

    localparam int RW = root_bits(COORD_BITS);
    localparam int W2 = rem_bits(COORD_BITS);

    logic [W2-1:0] trial;
    logic          take;
    logic [W2-1:0] rem_reg;
    logic [RW-1:0] root_reg;
    logic [SW-1:0] side_reg;

    // (r + 2^b)^2 - r^2 = r * 2^(b+1) + 2^(2b)
    assign trial = (W2'(root_in) << (BIT + 1)) + (W2'(1) << (2 * BIT));
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= take ? (rem_in - trial) : rem_in;
            root_reg <= take ? (root_in | (RW'(1) << BIT)) : root_in;
            side_reg <= side_in;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
    assign side_out = side_reg;
endmodule

/* rtl/copv_div_cell.sv */
// One quotient bit of the paired x/y restoring divider.
// Depends on copv_pkg.
module copv_div_cell #(
    parameter int COORD_BITS = 16,
    parameter int BIT        = 0,
    parameter int SW         = 1
) (
    input  logic                                       clk,
    input  logic                                       en,
    input  logic [copv_pkg::rem_bits(COORD_BITS)-1:0]  rem_x_in,
    input  logic [copv_pkg::rem_bits(COORD_BITS)-1:0]  rem_y_in,
    input  logic [copv_pkg::root_bits(COORD_BITS)-1:0] q_x_in,
    input  logic [copv_pkg::root_bits(COORD_BITS)-1:0] q_y_in,
    input  logic [copv_pkg::root_bits(COORD_BITS)-1:0] den_in,
    input  logic [SW-1:0]                              side_in,
    output logic [copv_pkg::rem_bits(COORD_BITS)-1:0]  rem_x_out,
    output logic [copv_pkg::rem_bits(COORD_BITS)-1:0]  rem_y_out,
    output logic [copv_pkg::root_bits(COORD_BITS)-1:0] q_x_out,
    output logic [copv_pkg::root_bits(COORD_BITS)-1:0] q_y_out,
    output logic [copv_pkg::root_bits(COORD_BITS)-1:0] den_out,
    output logic [SW-1:0]                              side_out
);
    import copv_pkg::*;

    localparam int RW = root_bits(COORD_BITS);
    localparam int W2 = rem_bits(COORD_BITS);

    logic [W2-1:0] trial;
    logic          take_x;
    logic          take_y;
    logic [W2-1:0] rem_x_reg;
    logic [W2-1:0] rem_y_reg;
    logic [RW-1:0] q_x_reg;
    logic [RW-1:0] q_y_reg;
    logic [RW-1:0] den_reg;
    logic [SW-1:0] side_reg;

    assign trial  = W2'(den_in) << BIT;
    assign take_x = (rem_x_in >= trial);
    assign take_y = (rem_y_in >= trial);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_x_reg <= take_x ? (rem_x_in - trial) : rem_x_in;
            rem_y_reg <= take_y ? (rem_y_in - trial) : rem_y_in;
            q_x_reg   <= take_x ? (q_x_in | (RW'(1) << BIT)) : q_x_in;
            q_y_reg   <= take_y ? (q_y_in | (RW'(1) << BIT)) : q_y_in;
            den_reg   <= den_in;
            side_reg  <= side_in;
        end
    end

    assign rem_x_out = rem_x_reg;
    assign rem_y_out = rem_y_reg;
    assign q_x_out   = q_x_reg;
    assign q_y_out   = q_y_reg;
    assign den_out   = den_reg;
    assign side_out  = side_reg;
endmodule

/* rtl/copv_checker.sv */
// Port-level checker for circle_overlap_push_vector, with its bind.
// Depends on circle_overlap_push_vector_assert.svh.
`include "circle_overlap_push_vector_assert.svh"

module copv_checker #(
    parameter int COORD_BITS = 16
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input logic [COORD_BITS+1:0] push_x,
    input logic [COORD_BITS+1:0] push_y,
    input logic                  in_contact
);
    `COPV_ASSERT_NOW(a_apart_zero, out_valid && !in_contact, push_x == '0 && push_y == '0, "push nonzero while apart")
    `COPV_ASSERT_NOW(a_ready_free, !out_valid || out_ready, in_ready, "input stalled with free output")
    `COPV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(push_x) && $stable(push_y) && $stable(in_contact), "stalled result changed")
endmodule

bind circle_overlap_push_vector copv_checker #(.COORD_BITS(COORD_BITS)) u_copv_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (in.ready),
    .out_valid  (out.valid),
    .out_ready  (out.ready),
    .push_x     (out.push_x),
    .push_y     (out.push_y),
    .in_contact (out.in_contact)
);
